/* rtl/gle_pkg.sv */
package gle_pkg;

  localparam int unsigned TableDepth   = 8192;
  localparam int unsigned AddrW        = $clog2(TableDepth);
  localparam int unsigned StringStore  = 10000;
  localparam int unsigned MaxStringLen = 100;
  localparam int unsigned EpochW       = 8;

  localparam logic [13:0] CodeLimit  = 14'(4096 - 3);
  localparam logic [13:0] StoreLimit = 14'(StringStore - MaxStringLen - 5);
  localparam logic [6:0]  LenCap     = 7'(MaxStringLen - 3);
  localparam logic [12:0] HashMult   = 13'd6577;
  localparam logic [EpochW-1:0] EpochMax = '1;

  localparam logic [2:0] AddrMinSize   = 3'd0;
  localparam logic [2:0] AddrColorBits = 3'd4;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [19:0]       key;
    logic [11:0]       code;
  } entry_t;

  function automatic logic [3:0] clamp_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [7:0] pixel_mask(input logic [3:0] size, input logic [3:0] bits);
    logic [3:0] b;
    logic [8:0] mb;
    logic [8:0] ms;
    b = (bits > 4'd8) ? 4'd8 : bits;
    mb = (9'd1 << b) - 9'd1;
    ms = (9'd1 << size) - 9'd1;
    return mb[7:0] & ms[7:0];
  endfunction

  function automatic logic [AddrW-1:0] hash_start(input logic [19:0] key);
    logic [25:0] p;
    p = key[12:0] * HashMult;
    return p[AddrW-1:0];
  endfunction

endpackage

/* rtl/gif_lzw_code_stream_encoder.sv */
// path to the first code: ST_CHECK per hash probe (skipped on the first pixel of a string),
// ST_FULL and ST_FULL2 on a table clear, ST_LAST, ST_END on the last pixel, code buffer, output
// input flow: one pixel at a time; the next is taken in ST_IDLE only after the codes of the
// last have drained, so any output stall holds the input
// reset: asynchronous, active low; the dictionary is swept after reset and again after
// every 255 table clears or image ends, with no pixel accepted meanwhile
module gif_lzw_code_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // color
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // code[11:0], code_width[15:12]
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_CHECK, ST_FULL, ST_FULL2, ST_LAST, ST_END, ST_DRAIN
  } state_e;

  state_e state_q;

  logic [3:0]  min_size_q, color_bits_q;
  logic [11:0] cur_code_q;
  logic [6:0]  cur_len_q;
  logic [12:0] entry_count_q;
  logic [13:0] store_used_q;
  logic [3:0]  width_q;
  logic        started_q;
  logic [3:0]  run_size_q;
  logic [7:0]  run_mask_q;
  logic [gle_pkg::EpochW-1:0] epoch_q;
  logic        sweep_pend_q;
  logic [gle_pkg::AddrW-1:0]  probe_q;
  logic [gle_pkg::AddrW-1:0]  sweep_q;
  logic [19:0] key_q;
  logic [7:0]  pix_q;
  logic        last_q;

  logic [11:0] buf_code_q [5];
  logic [3:0]  buf_w_q [5];
  logic [2:0]  cnt_q, rd_q;

  logic        m_valid_q, m_last_q;
  logic [15:0] m_data_q;

  gle_pkg::entry_t mem [gle_pkg::TableDepth];
  gle_pkg::entry_t rdata_q;
  logic [gle_pkg::AddrW-1:0] rd_addr, wr_addr;
  gle_pkg::entry_t wdata;
  logic        we;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == gle_pkg::AddrMinSize) prdata = {28'd0, min_size_q};
    else if (paddr == gle_pkg::AddrColorBits) prdata = {28'd0, color_bits_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q   <= 4'd8;
      color_bits_q <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr == gle_pkg::AddrMinSize) min_size_q <= pwdata[3:0];
      else if (paddr == gle_pkg::AddrColorBits) color_bits_q <= pwdata[3:0];
    end
  end

  // accept-cycle view of the image start
  logic [3:0]  new_size;
  logic [7:0]  new_mask, pix_in;
  logic [6:0]  len_eff;
  logic [19:0] key_in;
  assign new_size = gle_pkg::clamp_size(min_size_q);
  assign new_mask = started_q ? run_mask_q : gle_pkg::pixel_mask(new_size, color_bits_q);
  assign pix_in   = s_axis_tdata_i & new_mask;
  assign len_eff  = started_q ? cur_len_q : 7'd0;
  assign key_in   = {cur_code_q, pix_in};

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  logic out_load;
  assign out_load = (state_q == ST_DRAIN) && (rd_q != cnt_q) &&
                    (!m_valid_q || m_axis_tready_i);

  // dictionary lookup
  logic valid_e, hit;
  logic [8:0]  clear_code;
  logic [11:0] end_code;
  logic [13:0] ec_sum, store_new, width_lim;
  logic [12:0] ec_new;
  assign valid_e    = (rdata_q.epoch == epoch_q);
  assign hit        = valid_e && (rdata_q.key == key_q);
  assign clear_code = 9'd1 << run_size_q;
  assign end_code   = 12'(clear_code) + 12'd1;
  assign ec_new     = entry_count_q + 13'd1;
  assign ec_sum     = 14'(ec_new) + 14'(end_code);
  assign store_new  = store_used_q + 14'(cur_len_q) + 14'd3;
  assign width_lim  = 14'd1 << width_q;

  always_comb begin
    rd_addr = probe_q + gle_pkg::AddrW'(1);
    if (state_q == ST_IDLE) rd_addr = gle_pkg::hash_start(key_in);
    we      = 1'b0;
    wr_addr = probe_q;
    wdata   = '{epoch: epoch_q, key: key_q, code: 12'(ec_sum)};
    if (state_q == ST_SWEEP) begin
      we      = 1'b1;
      wr_addr = sweep_q;
      wdata   = '0;
    end else if (state_q == ST_CHECK && !(valid_e && !hit) && !hit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      cur_code_q    <= '0;
      cur_len_q     <= '0;
      entry_count_q <= '0;
      store_used_q  <= 14'd1;
      width_q       <= 4'd9;
      started_q     <= 1'b0;
      run_size_q    <= 4'd8;
      run_mask_q    <= 8'hff;
      epoch_q       <= '0;
      sweep_pend_q  <= 1'b0;
      probe_q       <= '0;
      sweep_q       <= '0;
      cnt_q         <= '0;
      rd_q          <= '0;
      m_valid_q     <= 1'b0;
      m_last_q      <= 1'b0;
      key_q         <= '0;
      pix_q         <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_SWEEP: begin
          sweep_q <= sweep_q + gle_pkg::AddrW'(1);
          if (sweep_q == '1) begin
            epoch_q      <= gle_pkg::EpochW'(1);
            sweep_pend_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            pix_q  <= pix_in;
            last_q <= s_axis_tlast_i;
            key_q  <= key_in;
            probe_q <= gle_pkg::hash_start(key_in);
            if (!started_q) begin
              run_size_q    <= new_size;
              run_mask_q    <= new_mask;
              width_q       <= new_size + 4'd1;
              entry_count_q <= '0;
              store_used_q  <= 14'd1;
              started_q     <= 1'b1;
              buf_code_q[0] <= 12'd1 << new_size;
              buf_w_q[0]    <= new_size + 4'd1;
              cnt_q         <= 3'd1;
            end
            if (len_eff == 7'd0) begin
              cur_code_q <= 12'(pix_in);
              cur_len_q  <= 7'd1;
              state_q    <= ST_LAST;
            end else begin
              cur_len_q <= cur_len_q + 7'd1;
              state_q   <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (valid_e && !hit) begin
            probe_q <= probe_q + gle_pkg::AddrW'(1);
          end else if (hit && cur_len_q < gle_pkg::LenCap) begin
            cur_code_q <= rdata_q.code;
            state_q    <= ST_LAST;
          end else begin
            buf_code_q[cnt_q] <= cur_code_q;
            buf_w_q[cnt_q]    <= width_q;
            cnt_q             <= cnt_q + 3'd1;
            entry_count_q     <= ec_new;
            if (!hit) store_used_q <= store_new;
            cur_len_q  <= 7'd1;
            cur_code_q <= 12'(pix_q);
            if (ec_sum == width_lim) width_q <= width_q + 4'd1;
            if (ec_sum > gle_pkg::CodeLimit ||
                (hit ? store_used_q : store_new) > gle_pkg::StoreLimit) begin
              state_q <= ST_FULL;
            end else begin
              state_q <= ST_LAST;
            end
          end
        end
        ST_FULL: begin
          buf_code_q[cnt_q] <= cur_code_q;
          buf_w_q[cnt_q]    <= width_q;
          cnt_q             <= cnt_q + 3'd1;
          state_q           <= ST_FULL2;
        end
        ST_FULL2: begin
          buf_code_q[cnt_q] <= 12'(clear_code);
          buf_w_q[cnt_q]    <= width_q;
          cnt_q             <= cnt_q + 3'd1;
          entry_count_q     <= '0;
          store_used_q      <= 14'd1;
          cur_len_q         <= '0;
          width_q           <= run_size_q + 4'd1;
          if (epoch_q == gle_pkg::EpochMax) sweep_pend_q <= 1'b1;
          else epoch_q <= epoch_q + gle_pkg::EpochW'(1);
          state_q <= ST_LAST;
        end
        ST_LAST: begin
          if (last_q) begin
            if (cur_len_q != 7'd0) begin
              buf_code_q[cnt_q] <= cur_code_q;
              buf_w_q[cnt_q]    <= width_q;
              cnt_q             <= cnt_q + 3'd1;
            end
            state_q <= ST_END;
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_END: begin
          buf_code_q[cnt_q] <= end_code;
          buf_w_q[cnt_q]    <= width_q;
          cnt_q             <= cnt_q + 3'd1;
          started_q         <= 1'b0;
          cur_len_q         <= '0;
          if (epoch_q == gle_pkg::EpochMax) sweep_pend_q <= 1'b1;
          else epoch_q <= epoch_q + gle_pkg::EpochW'(1);
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (rd_q == cnt_q) begin
            cnt_q   <= '0;
            rd_q    <= '0;
            state_q <= sweep_pend_q ? ST_SWEEP : ST_IDLE;
          end else if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= {buf_w_q[rd_q], buf_code_q[rd_q]};
            m_last_q  <= (rd_q == cnt_q - 3'd1);
            rd_q      <= rd_q + 3'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* rtl/gle_checker.sv */
module gle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // output held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // one pixel at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("pixel accepted back to back");

  // code width in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:12] >= 4'd3 && m_axis_tdata_o[15:12] <= 4'd12)
    else $error("code width out of range");

endmodule

bind gif_lzw_code_stream_encoder gle_checker u_gle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  width;
    logic        last;
  } code_t;

  typedef struct {
    logic [7:0] color;
    logic       last;
    int         n_typed;
    code_t      typed [3];
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gif_lzw_code_stream_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // color
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // code[11:0], code_width[15:12]
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // encoder model state
  int unsigned size_reg = 8, bits_reg = 8;
  int unsigned lzw_size, lzw_mask, cur_code, cur_len, entries, store_used, width_now;
  bit          in_image = 1'b0;
  logic [11:0] strings [int unsigned];
  code_t       pending_codes [$];
  code_t       new_codes [$];
  int          errors = 0;
  bit          quiet = 1'b0;

  function automatic void clear_strings();
    strings.delete();
    entries = 0;
    cur_len = 0;
    store_used = 1;
    width_now = lzw_size + 1;
  endfunction

  function automatic void put_code(int unsigned c);
    code_t x;
    x.code = c[11:0];
    x.width = width_now[3:0];
    x.last = 1'b0;
    new_codes.push_back(x);
  endfunction

  // computes the codes caused by one pixel into new_codes
  function automatic void encode_pixel(logic [7:0] color, logic last);
    int unsigned s, b, pix, clr, eoi, key;
    bit hit;
    new_codes.delete();
    if (!in_image) begin
      s = size_reg < 2 ? 2 : (size_reg > 8 ? 8 : size_reg);
      b = bits_reg > 8 ? 8 : bits_reg;
      lzw_size = s;
      lzw_mask = ((1 << b) - 1) & ((1 << s) - 1);
      width_now = s + 1;
      put_code(1 << s);
      clear_strings();
      in_image = 1'b1;
    end
    clr = 1 << lzw_size;
    eoi = clr + 1;
    pix = color & lzw_mask;
    cur_len++;
    if (cur_len == 1) begin
      cur_code = pix;
    end else begin
      key = ((cur_code & 12'hfff) << 8) | pix;
      hit = strings.exists(key);
      if (hit && cur_len < gle_pkg::LenCap) begin
        cur_code = strings[key];
      end else begin
        put_code(cur_code);
        entries++;
        if (!hit) begin
          strings[key] = 12'(entries + eoi);
          store_used += cur_len + 3;
        end
        cur_len = 1;
        cur_code = pix;
        if (entries + eoi == (1 << width_now)) width_now++;
        if (entries + eoi > gle_pkg::CodeLimit || store_used > gle_pkg::StoreLimit) begin
          put_code(cur_code);
          put_code(clr);
          clear_strings();
        end
      end
    end
    if (last) begin
      if (cur_len > 0) put_code(cur_code);
      put_code(eoi);
      in_image = 1'b0;
      cur_len = 0;
    end
    if (new_codes.size() > 0) new_codes[new_codes.size() - 1].last = 1'b1;
  endfunction

  task automatic send_pixel(logic [7:0] color, logic last, int n_typed = 0,
                            code_t typed [3] = '{default: '0});
    int gap;
    encode_pixel(color, last);
    if (n_typed > 0) begin
      new_codes.delete();
      for (int i = 0; i < n_typed; i++) new_codes.push_back(typed[i]);
    end
    foreach (new_codes[i]) pending_codes.push_back(new_codes[i]);
    if (!quiet && $urandom_range(99) < 8) begin
      gap = $urandom_range(3, 1);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= color;
    s_last <= last;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic idle_source();
    s_valid <= 1'b0;
    while (pending_codes.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [3:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {28'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == gle_pkg::AddrMinSize) size_reg = value;
    else size_reg = size_reg;
    if (addr == gle_pkg::AddrColorBits) bits_reg = value;
  endtask

  task automatic random_images(int n_pix, int max_len);
    int left;
    left = 0;
    for (int i = 0; i < n_pix; i++) begin
      if (left == 0) left = $urandom_range(max_len, 1);
      left--;
      send_pixel($urandom_range(255), left == 0 || i == n_pix - 1);
    end
  endtask

  // output side: random stalls and in-order check
  always @(posedge clk_i) begin
    code_t want;
    m_ready <= quiet || ($urandom_range(99) >= 8);
    if (rst_ni && m_valid && m_ready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code %h width %0d last %b", $time, m_data[11:0],
                 m_data[15:12], m_last);
        errors++;
      end else begin
        want = pending_codes.pop_front();
        if (m_data[11:0] !== want.code || m_data[15:12] !== want.width ||
            m_last !== want.last) begin
          $display("%0t: expected code %h width %0d last %b, got %h width %0d last %b",
                   $time, want.code, want.width, want.last, m_data[11:0],
                   m_data[15:12], m_last);
          errors++;
        end
      end
    end
  end

  row_t rows [] = '{
    '{8'hff, 1'b1, 3, '{'{12'd256, 4'd9, 1'b0}, '{12'd255, 4'd9, 1'b0},
                        '{12'd257, 4'd9, 1'b1}}},
    '{8'h00, 1'b0, 1, '{'{12'd256, 4'd9, 1'b1}, '0, '0}},
    '{8'h00, 1'b0, 0, '{default: '0}},
    '{8'h00, 1'b0, 0, '{default: '0}},
    '{8'h00, 1'b0, 0, '{default: '0}},
    '{8'h80, 1'b0, 0, '{default: '0}},
    '{8'h7f, 1'b0, 0, '{default: '0}},
    '{8'hff, 1'b0, 0, '{default: '0}},
    '{8'h55, 1'b0, 0, '{default: '0}},
    '{8'haa, 1'b0, 0, '{default: '0}},
    '{8'h55, 1'b0, 0, '{default: '0}},
    '{8'haa, 1'b0, 0, '{default: '0}},
    '{8'h55, 1'b0, 0, '{default: '0}},
    '{8'haa, 1'b1, 0, '{default: '0}},
    '{8'h01, 1'b0, 0, '{default: '0}},
    '{8'h01, 1'b1, 0, '{default: '0}}
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_pixel(rows[i].color, rows[i].last, rows[i].n_typed, rows[i].typed);
    idle_source();
    // small code size with wide pixels, no color bits, out-of-range registers
    write_reg(gle_pkg::AddrMinSize, 4'd2);
    write_reg(gle_pkg::AddrColorBits, 4'd1);
    random_images(30, 12);
    idle_source();
    write_reg(gle_pkg::AddrColorBits, 4'd0);
    random_images(10, 5);
    idle_source();
    write_reg(gle_pkg::AddrMinSize, 4'd15);
    write_reg(gle_pkg::AddrColorBits, 4'd15);
    random_images(40, 20);
    idle_source();
    write_reg(gle_pkg::AddrMinSize, 4'd0);
    write_reg(gle_pkg::AddrColorBits, 4'd8);
    random_images(40, 20);
    idle_source();
    // long run of one color grows strings
    write_reg(gle_pkg::AddrMinSize, 4'd3);
    write_reg(gle_pkg::AddrColorBits, 4'd0);
    for (int i = 0; i < 60; i++) send_pixel($urandom_range(255), i == 59);
    idle_source();
    // long stretch with no idling
    write_reg(gle_pkg::AddrMinSize, 4'd8);
    write_reg(gle_pkg::AddrColorBits, 4'd8);
    quiet = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel($urandom_range(255), i == 59);
    quiet = 1'b0;
    idle_source();
    write_reg(gle_pkg::AddrMinSize, 4'd5);
    write_reg(gle_pkg::AddrColorBits, 4'd4);
    random_images(50, 40);
    idle_source();
    write_reg(gle_pkg::AddrMinSize, 4'd8);
    write_reg(gle_pkg::AddrColorBits, 4'd8);
    random_images(54, 60);
    idle_source();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gle_pkg.sv
rtl/gif_lzw_code_stream_encoder.sv
rtl/gle_checker.sv
tb/sv/tb.sv
